/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for clocked concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clk unless rst is high
`define EFLA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that a trigger is followed in the next cycle by a consequence
`define EFLA_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/efla_pkg.sv */
// ----------------------------------------------------------------------------
// efla_pkg
// Types, codes and constants of the free-list heap allocator.
// ----------------------------------------------------------------------------
package efla_pkg;

   localparam int unsigned HEAP_BYTES      = 1048576;
   localparam int unsigned MIN_BLOCK_BYTES = 16;
   localparam int unsigned HEAP_WORDS      = HEAP_BYTES / 4;
   localparam int unsigned WADDR_W         = $clog2(HEAP_WORDS);
   localparam int unsigned WALK_LIMIT      = HEAP_BYTES / MIN_BLOCK_BYTES + 1;
   localparam int unsigned WALK_W          = $clog2(WALK_LIMIT + 1);

   localparam logic [20:0] RESET_CHUNK = 21'd4096;
   localparam logic [31:0] RESET_HEAD  = 32'd32;
   localparam logic [20:0] RESET_BREAK = 21'd4128;
   localparam int unsigned INIT_WRITES = 8;

   localparam logic        ACT_ALLOC = 1'b0;
   localparam logic        ACT_FREE  = 1'b1;

   localparam logic [1:0]  STATUS_OK   = 2'd0;
   localparam logic [1:0]  STATUS_ZERO = 2'd1;
   localparam logic [1:0]  STATUS_OOM  = 2'd2;

   localparam logic        CSR_GROWTH_CHUNK = 1'b0;

   typedef enum logic [5:0] {
      ST_CLEAR, ST_INIT, ST_IDLE,
      ST_FF_RD, ST_FF_CHK, ST_FF_NX, ST_FF_LD,
      ST_GR_MAX, ST_GR_SIZE, ST_GR_BRK, ST_GR_EPI, ST_GR_CHK,
      ST_TK_RD, ST_TK_CMP, ST_TK_SEL, ST_TK_UNL, ST_TK_NXT, ST_TK_TAG, ST_TK_MRG,
      ST_TK_REST,
      ST_FR_RD, ST_FR_LD, ST_FR_CHK, ST_FR_MRG,
      ST_DONE,
      ST_T0, ST_T1, ST_T2,
      ST_U0, ST_U1, ST_U2, ST_U3,
      ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
      ST_M10, ST_M11, ST_M12, ST_M13, ST_M14, ST_M15, ST_M16, ST_M17
   } state_type;

   function automatic logic [WADDR_W-1:0] init_addr(input logic [2:0] idx);
      logic [WADDR_W-1:0] a;
      unique case (idx)
         3'd0:    a = WADDR_W'(1);
         3'd1:    a = WADDR_W'(4);
         3'd2:    a = WADDR_W'(5);
         3'd3:    a = WADDR_W'(7);
         3'd4:    a = WADDR_W'(1030);
         3'd5:    a = WADDR_W'(1031);
         3'd6:    a = WADDR_W'(9);
         default: a = WADDR_W'(2);
      endcase
      return a;
   endfunction

   function automatic logic [31:0] init_data(input logic [2:0] idx);
      logic [31:0] d;
      unique case (idx)
         3'd0:    d = 32'd17;
         3'd1:    d = 32'd17;
         3'd2:    d = 32'd1;
         3'd3:    d = 32'd4096;
         3'd4:    d = 32'd4096;
         3'd5:    d = 32'd1;
         3'd6:    d = 32'd8;
         default: d = 32'd32;
      endcase
      return d;
   endfunction

endpackage

/* hw/rtl/explicit_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_unit
// First-fit heap allocator with boundary tags and a LIFO explicit free list.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the 262144-word heap memory to zero, one word a
// cycle, then writes 8 setup words, and busy stays high until it is done.
// All work goes through one single-port heap memory (one access a cycle,
// read data in the next cycle) and one shared 32-bit adder under a sequencer.
// A zero-size allocate is answered in the next cycle, without raising busy.
// An allocate walks the free list first-fit, takes the block that fits, with
// or without a split and merge, and grows the heap when no block fits. A free
// is either rejected or merged into the free list. Each item gives one
// result, shown for exactly one cycle on rsp_valid; the receiver cannot stall
// it. A new item is taken whenever busy is low.
// ----------------------------------------------------------------------------
module explicit_free_list_allocator_unit
   import efla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [20:0] req_request_size,
   input  logic [19:0] req_block_address,
   output logic        rsp_valid,
   output logic [19:0] rsp_payload_address,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [31:0] MASK8  = 32'hFFFF_FFF8;
   localparam logic [31:0] MINUS4 = 32'hFFFF_FFFC;
   localparam logic [31:0] MINUS8 = 32'hFFFF_FFF8;

   state_type state_ff, state_in;
   state_type ret_tags_ff, ret_tags_in;
   state_type ret_unl_ff, ret_unl_in;
   state_type ret_mrg_ff, ret_mrg_in;

   logic [31:0] bp_ff, bp_in, sz_ff, sz_in, tmp_ff, tmp_in;
   logic [31:0] need_ff, need_in, have_ff, have_in, dif_ff, dif_in, gb_ff, gb_in;
   logic [31:0] mp_ff, mp_in, psz_ff, psz_in, nsz_ff, nsz_in, nx_ff, nx_in;
   logic [31:0] ux_ff, ux_in, up_ff, up_in, us_ff, us_in, head_ff, head_in;
   logic        ge_ff, ge_in, pa_ff, pa_in, na_ff, na_in, tal_ff, tal_in;
   logic        al_ff, al_in;
   logic [20:0] brk_ff, brk_in, chunk_ff, chunk_in;
   logic [WALK_W-1:0]  cnt_ff, cnt_in;
   logic [19:0] res_ff, res_in, blk_ff, blk_in;
   logic [WADDR_W-1:0] clr_ff, clr_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [31:0] op_a, op_b;
   logic        op_c;
   logic [32:0] alu_sum;

   logic [31:0] mem [HEAP_WORDS];
   logic [31:0] mem_q;
   logic [WADDR_W-1:0] mem_addr;
   logic [31:0] mem_wdata;
   logic        mem_we;

   logic        cfg_wr;
   logic [31:0] rd_size;
   logic        split;
   logic        free_ok;

   assign alu_sum = {1'b0, op_a} + {1'b0, op_b} + {32'd0, op_c};
   assign rd_size = mem_q & MASK8;
   assign cfg_wr  = psel && penable && pwrite;
   assign split   = ge_ff && (dif_ff >= 32'(MIN_BLOCK_BYTES));

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign pready              = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_GROWTH_CHUNK) begin
         prdata = {11'd0, chunk_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         head_ff      <= RESET_HEAD;
         brk_ff       <= RESET_BREAK;
         chunk_ff     <= RESET_CHUNK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         brk_ff       <= brk_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_tags_ff   <= ret_tags_in;
      ret_unl_ff    <= ret_unl_in;
      ret_mrg_ff    <= ret_mrg_in;
      bp_ff         <= bp_in;
      sz_ff         <= sz_in;
      tmp_ff        <= tmp_in;
      need_ff       <= need_in;
      have_ff       <= have_in;
      dif_ff        <= dif_in;
      gb_ff         <= gb_in;
      mp_ff         <= mp_in;
      psz_ff        <= psz_in;
      nsz_ff        <= nsz_in;
      nx_ff         <= nx_in;
      ux_ff         <= ux_in;
      up_ff         <= up_in;
      us_ff         <= us_in;
      ge_ff         <= ge_in;
      pa_ff         <= pa_in;
      na_ff         <= na_in;
      tal_ff        <= tal_in;
      al_ff         <= al_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      blk_ff        <= blk_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      ret_tags_in   = ret_tags_ff;
      ret_unl_in    = ret_unl_ff;
      ret_mrg_in    = ret_mrg_ff;
      bp_in         = bp_ff;
      sz_in         = sz_ff;
      tmp_in        = tmp_ff;
      need_in       = need_ff;
      have_in       = have_ff;
      dif_in        = dif_ff;
      gb_in         = gb_ff;
      mp_in         = mp_ff;
      psz_in        = psz_ff;
      nsz_in        = nsz_ff;
      nx_in         = nx_ff;
      ux_in         = ux_ff;
      up_in         = up_ff;
      us_in         = us_ff;
      head_in       = head_ff;
      ge_in         = ge_ff;
      pa_in         = pa_ff;
      na_in         = na_ff;
      tal_in        = tal_ff;
      al_in         = al_ff;
      brk_in        = brk_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      blk_in        = blk_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      chunk_in      = chunk_ff;
      op_a          = '0;
      op_b          = '0;
      op_c          = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = '0;
      free_ok       = 1'b0;

      if (cfg_wr && (paddr[2] == CSR_GROWTH_CHUNK)) begin
         chunk_in = pwdata[20:0];
      end

      mem_addr = alu_sum[WADDR_W+1:2];

      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            mem_addr  = init_addr(idx_ff);
            mem_wdata = init_data(idx_ff);
            mem_we    = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == 3'(INIT_WRITES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            op_a = {11'd0, req_request_size};
            op_b = 32'd15;
            if (start) begin
               if (req_action == ACT_FREE) begin
                  blk_in   = req_block_address;
                  res_in   = '0;
                  state_in = ST_FR_RD;
               end else if (req_request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_ZERO;
               end else begin
                  need_in  = (req_request_size <= 21'd8) ? 32'(MIN_BLOCK_BYTES)
                                                        : (alu_sum[31:0] & MASK8);
                  bp_in    = head_ff;
                  cnt_in   = '0;
                  state_in = ST_FF_RD;
               end
            end
         end
         ST_FF_RD: begin
            op_a     = bp_ff;
            op_b     = MINUS4;
            state_in = ST_FF_CHK;
         end
         ST_FF_CHK: begin
            op_a = rd_size;
            op_b = ~need_ff;
            op_c = 1'b1;
            if (mem_q[0] || (cnt_ff == WALK_W'(WALK_LIMIT))) begin
               state_in = ST_GR_MAX;
            end else if (alu_sum[32]) begin
               state_in = (bp_ff == '0) ? ST_GR_MAX : ST_TK_RD;
            end else begin
               state_in = ST_FF_NX;
            end
         end
         ST_FF_NX: begin
            op_a     = bp_ff;
            op_b     = 32'd4;
            state_in = ST_FF_LD;
         end
         ST_FF_LD: begin
            bp_in    = mem_q;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_FF_RD;
         end
         ST_GR_MAX: begin
            op_a     = {11'd0, chunk_ff};
            op_b     = ~need_ff;
            op_c     = 1'b1;
            gb_in    = alu_sum[32] ? {11'd0, chunk_ff} : need_ff;
            state_in = ST_GR_SIZE;
         end
         ST_GR_SIZE: begin
            op_a     = {2'd0, gb_ff[31:2]};
            op_b     = {31'd0, gb_ff[2]};
            sz_in    = (alu_sum[31:0] < 32'd4) ? 32'(MIN_BLOCK_BYTES)
                                               : {alu_sum[29:0], 2'b00};
            state_in = ST_GR_BRK;
         end
         ST_GR_BRK: begin
            op_a = {11'd0, brk_ff};
            op_b = sz_ff;
            if (alu_sum > 33'(HEAP_BYTES)) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_OOM;
               state_in      = ST_IDLE;
            end else begin
               bp_in       = {11'd0, brk_ff};
               brk_in      = alu_sum[20:0];
               tal_in      = 1'b0;
               ret_tags_in = ST_GR_EPI;
               state_in    = ST_T0;
            end
         end
         ST_GR_EPI: begin
            op_a       = {11'd0, brk_ff};
            op_b       = MINUS4;
            mem_we     = 1'b1;
            mem_wdata  = 32'd1;
            ret_mrg_in = ST_GR_CHK;
            state_in   = ST_M0;
         end
         ST_GR_CHK: begin
            if (bp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_OOM;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_TK_RD;
            end
         end
         ST_TK_RD: begin
            op_a     = bp_ff;
            op_b     = MINUS4;
            res_in   = bp_ff[19:0];
            state_in = ST_TK_CMP;
         end
         ST_TK_CMP: begin
            op_a     = rd_size;
            op_b     = ~need_ff;
            op_c     = 1'b1;
            have_in  = rd_size;
            dif_in   = alu_sum[31:0];
            ge_in    = alu_sum[32];
            state_in = ST_TK_SEL;
         end
         ST_TK_SEL: begin
            tal_in   = 1'b1;
            state_in = ST_T0;
            if (split) begin
               sz_in       = need_ff;
               ret_tags_in = ST_TK_UNL;
            end else begin
               sz_in       = have_ff;
               ret_tags_in = ST_TK_REST;
            end
         end
         ST_TK_UNL: begin
            ux_in      = bp_ff;
            ret_unl_in = ST_TK_NXT;
            state_in   = ST_U0;
         end
         ST_TK_NXT: begin
            op_a     = bp_ff;
            op_b     = need_ff;
            bp_in    = alu_sum[31:0];
            state_in = ST_TK_TAG;
         end
         ST_TK_TAG: begin
            sz_in       = dif_ff;
            tal_in      = 1'b0;
            ret_tags_in = ST_TK_MRG;
            state_in    = ST_T0;
         end
         ST_TK_MRG: begin
            ret_mrg_in = ST_DONE;
            state_in   = ST_M0;
         end
         ST_TK_REST: begin
            ux_in      = bp_ff;
            ret_unl_in = ST_DONE;
            state_in   = ST_U0;
         end
         ST_FR_RD: begin
            op_a     = {12'd0, blk_ff};
            op_b     = MINUS4;
            state_in = ST_FR_LD;
         end
         ST_FR_LD: begin
            sz_in    = rd_size;
            al_in    = mem_q[0];
            state_in = ST_FR_CHK;
         end
         ST_FR_CHK: begin
            op_a    = {12'd0, blk_ff};
            op_b    = sz_ff;
            free_ok = (blk_ff[2:0] == 3'd0) && (blk_ff >= 20'd32) &&
                      ({1'b0, blk_ff} < brk_ff) && al_ff &&
                      (sz_ff >= 32'(MIN_BLOCK_BYTES)) &&
                      (alu_sum <= {12'd0, brk_ff});
            if (free_ok) begin
               bp_in       = {12'd0, blk_ff};
               tal_in      = 1'b0;
               ret_tags_in = ST_FR_MRG;
               state_in    = ST_T0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FR_MRG: begin
            ret_mrg_in = ST_DONE;
            state_in   = ST_M0;
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = res_ff;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         ST_T0: begin
            op_a      = bp_ff;
            op_b      = MINUS4;
            mem_we    = 1'b1;
            mem_wdata = sz_ff | {31'd0, tal_ff};
            state_in  = ST_T1;
         end
         ST_T1: begin
            op_a     = bp_ff;
            op_b     = sz_ff & MASK8;
            tmp_in   = alu_sum[31:0];
            state_in = ST_T2;
         end
         ST_T2: begin
            op_a      = tmp_ff;
            op_b      = MINUS8;
            mem_we    = 1'b1;
            mem_wdata = sz_ff | {31'd0, tal_ff};
            state_in  = ret_tags_ff;
         end
         ST_U0: begin
            op_a     = ux_ff;
            state_in = ST_U1;
         end
         ST_U1: begin
            op_a     = ux_ff;
            op_b     = 32'd4;
            up_in    = mem_q;
            state_in = ST_U2;
         end
         ST_U2: begin
            op_a  = up_ff;
            op_b  = 32'd4;
            us_in = mem_q;
            if (up_ff != '0) begin
               mem_we    = 1'b1;
               mem_wdata = mem_q;
            end else begin
               head_in = mem_q;
            end
            state_in = ST_U3;
         end
         ST_U3: begin
            op_a      = us_ff;
            mem_we    = 1'b1;
            mem_wdata = up_ff;
            state_in  = ret_unl_ff;
         end
         ST_M0: begin
            op_a     = bp_ff;
            op_b     = MINUS8;
            state_in = ST_M1;
         end
         ST_M1: begin
            op_a     = bp_ff;
            op_b     = ~rd_size;
            op_c     = 1'b1;
            mp_in    = alu_sum[31:0];
            state_in = ST_M2;
         end
         ST_M2: begin
            op_a     = bp_ff;
            op_b     = MINUS4;
            state_in = ST_M3;
         end
         ST_M3: begin
            sz_in    = rd_size;
            state_in = ST_M4;
         end
         ST_M4: begin
            op_a     = bp_ff;
            op_b     = sz_ff;
            nx_in    = alu_sum[31:0];
            state_in = ST_M5;
         end
         ST_M5: begin
            op_a     = mp_ff;
            op_b     = MINUS4;
            state_in = ST_M6;
         end
         ST_M6: begin
            op_a     = mp_ff;
            op_b     = rd_size;
            psz_in   = rd_size;
            tmp_in   = alu_sum[31:0];
            state_in = ST_M7;
         end
         ST_M7: begin
            op_a     = tmp_ff;
            op_b     = MINUS8;
            state_in = ST_M8;
         end
         ST_M8: begin
            op_a     = nx_ff;
            op_b     = MINUS4;
            pa_in    = mem_q[0] || (mp_ff == bp_ff);
            state_in = ST_M9;
         end
         ST_M9: begin
            nsz_in   = rd_size;
            na_in    = mem_q[0];
            state_in = ST_M10;
         end
         ST_M10: begin
            op_a = sz_ff;
            op_b = psz_ff;
            if (!pa_ff) begin
               sz_in = alu_sum[31:0];
            end
            state_in = ST_M11;
         end
         ST_M11: begin
            op_a = sz_ff;
            op_b = nsz_ff;
            if (!na_ff) begin
               sz_in = alu_sum[31:0];
            end
            state_in = ST_M12;
         end
         ST_M12: begin
            if (!pa_ff) begin
               ux_in      = mp_ff;
               ret_unl_in = ST_M13;
               state_in   = ST_U0;
            end else begin
               state_in = ST_M13;
            end
         end
         ST_M13: begin
            if (!na_ff) begin
               ux_in      = nx_ff;
               ret_unl_in = ST_M14;
               state_in   = ST_U0;
            end else begin
               state_in = ST_M14;
            end
         end
         ST_M14: begin
            if (!pa_ff) begin
               bp_in = mp_ff;
            end
            if (!(pa_ff && na_ff)) begin
               tal_in      = 1'b0;
               ret_tags_in = ST_M15;
               state_in    = ST_T0;
            end else begin
               state_in = ST_M15;
            end
         end
         ST_M15: begin
            op_a      = bp_ff;
            op_b      = 32'd4;
            mem_we    = 1'b1;
            mem_wdata = head_ff;
            state_in  = ST_M16;
         end
         ST_M16: begin
            op_a      = head_ff;
            mem_we    = 1'b1;
            mem_wdata = bp_ff;
            state_in  = ST_M17;
         end
         ST_M17: begin
            op_a      = bp_ff;
            mem_we    = 1'b1;
            mem_wdata = '0;
            head_in   = bp_ff;
            state_in  = ret_mrg_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/efla_checker.sv */
// ----------------------------------------------------------------------------
// efla_checker
// Port-level checks of the free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efla_checker
   import efla_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_action,
   input logic [20:0] req_request_size,
   input logic        rsp_valid,
   input logic [19:0] rsp_payload_address,
   input logic [1:0]  rsp_status
);

   logic zero_beat;
   logic work_beat;
   logic zero_answer;
   logic fail_beat;
   logic addr_clear;
   logic status_legal;

   assign zero_beat    = start && !busy && (req_action == ACT_ALLOC) &&
                         (req_request_size == '0);
   assign work_beat    = start && !busy && !zero_beat;
   assign zero_answer  = rsp_valid && (rsp_status == STATUS_ZERO);
   assign fail_beat    = rsp_valid && (rsp_status != STATUS_OK);
   assign addr_clear   = (rsp_payload_address == '0);
   assign status_legal = (rsp_status == STATUS_OK) || (rsp_status == STATUS_ZERO) ||
                         (rsp_status == STATUS_OOM);

   `EFLA_ASSERT_NEXT(zero_size_answers, clock, reset, zero_beat, zero_answer, "no zero-size answer")
   `EFLA_ASSERT_NEXT(work_holds_busy, clock, reset, work_beat, busy, "beat did not raise busy")
   `EFLA_ASSERT(fail_has_no_address, clock, reset, fail_beat |-> addr_clear, "failure has address")
   `EFLA_ASSERT(status_known, clock, reset, rsp_valid |-> status_legal, "unknown status code")

endmodule

bind explicit_free_list_allocator_unit efla_checker u_efla_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_action          (req_action),
   .req_request_size    (req_request_size),
   .rsp_valid           (rsp_valid),
   .rsp_payload_address (rsp_payload_address),
   .rsp_status          (rsp_status)
);
